@@ rtl/copl_pkg.sv @@
`default_nettype none
package copl_pkg;

    localparam int MAX_IN_MAPS  = 4;
    localparam int MAX_OUT_MAPS = 8;
    localparam int MAX_DIM      = 64;
    localparam int MAX_KERNEL   = 7;

    localparam int KSLOTS    = MAX_KERNEL * MAX_KERNEL * MAX_IN_MAPS;
    localparam int KROWS     = KSLOTS / MAX_IN_MAPS;
    localparam int PIX_DEPTH = MAX_DIM * MAX_DIM;
    localparam int PIX_AW    = $clog2(PIX_DEPTH);
    localparam int WB_DEPTH  = MAX_OUT_MAPS * KROWS;
    localparam int WB_AW     = $clog2(WB_DEPTH);
    localparam int ACC_W     = 40;
    localparam int DIV_NW    = 14;
    localparam int DIV_DW    = 8;
    localparam int RES_W     = 28;

    typedef logic [1:0] op_t;
    localparam op_t OP_WEIGHT = 2'd0;
    localparam op_t OP_PIXEL  = 2'd1;
    localparam op_t OP_QUERY  = 2'd2;

    typedef logic [2:0] cfg_idx_t;
    localparam cfg_idx_t CFG_IN_WIDTH   = 3'd0;
    localparam cfg_idx_t CFG_IN_HEIGHT  = 3'd1;
    localparam cfg_idx_t CFG_OUT_WIDTH  = 3'd2;
    localparam cfg_idx_t CFG_OUT_HEIGHT = 3'd3;
    localparam cfg_idx_t CFG_KERNEL_W   = 3'd4;
    localparam cfg_idx_t CFG_KERNEL_H   = 3'd5;
    localparam cfg_idx_t CFG_NUM_MAPS   = 3'd6;
    localparam cfg_idx_t CFG_LEAK       = 3'd7;

    typedef struct packed {
        logic wr_weight;
        logic wr_pixel;
        logic load;
        logic scan_init;
        logic scan_step;
        logic mul;
        logic round;
        logic out_load;
    } copl_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic scan_last;
        logic pipe_busy;
        logic out_free;
    } copl_stat_t;

    function automatic logic [6:0] clamp_dim(input logic [6:0] v);
        logic [6:0] r;
        if (v == 7'd0)
            r = 7'd1;
        else if (v > 7'(MAX_DIM))
            r = 7'(MAX_DIM);
        else
            r = v;
        return r;
    endfunction

    function automatic logic [2:0] clamp_kernel(input logic [2:0] v);
        logic [2:0] r;
        if (v == 3'd0)
            r = 3'd1;
        else if (v > 3'(MAX_KERNEL))
            r = 3'(MAX_KERNEL);
        else
            r = v;
        return r;
    endfunction

    function automatic logic [2:0] clamp_maps(input logic [2:0] v);
        logic [2:0] r;
        if (v == 3'd0)
            r = 3'd1;
        else if (v > 3'(MAX_IN_MAPS))
            r = 3'(MAX_IN_MAPS);
        else
            r = v;
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/copl_ram.sv @@
`default_nettype none
module copl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ rtl/copl_div.sv @@
`default_nettype none
module copl_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [copl_pkg::DIV_NW-1:0] num,
    input  wire logic [copl_pkg::DIV_DW-1:0] den,
    output logic                            busy,
    output logic      [copl_pkg::DIV_NW-1:0] quo
);
    import copl_pkg::*;

    localparam int CNT_W = $clog2(DIV_NW);

    logic              busy_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_DW-1:0] den_reg;
    logic [DIV_NW-1:0] quo_reg;
    logic [DIV_DW:0]   trial;
    logic              fits;

    assign trial = {rem_reg, quo_reg[DIV_NW-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(DIV_NW - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIV_NW-2:0], fits};
            rem_reg <= fits ? DIV_DW'(trial - {1'b0, den_reg}) : DIV_DW'(trial);
        end
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;

endmodule
`default_nettype wire

@@ rtl/copl_ctrl.sv @@
`default_nettype none
module copl_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire copl_pkg::op_t          op,
    output logic                        in_ready,
    input  wire copl_pkg::copl_stat_t   stat,
    output copl_pkg::copl_cmd_t         cmd
);
    import copl_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SCAN,
        ST_DRAIN,
        ST_MUL,
        ST_ROUND,
        ST_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd           = '0;
        state_next    = state_reg;
        cmd.wr_weight = accept && (op == OP_WEIGHT);
        cmd.wr_pixel  = accept && (op == OP_PIXEL);
        cmd.load      = accept && (op == OP_QUERY);
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (!stat.div_busy)
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.round  = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/copl_dp.sv @@
`default_nettype none
module copl_dp (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    input  wire copl_pkg::cfg_idx_t   cfg_index,
    input  wire logic [15:0]          cfg_data,
    input  wire logic [2:0]           out_map,
    input  wire logic [1:0]           in_map,
    input  wire logic [5:0]           pos_x,
    input  wire logic [5:0]           pos_y,
    input  wire logic [7:0]           weight_index,
    input  wire logic signed [15:0]   data_value,
    input  wire copl_pkg::copl_cmd_t  cmd,
    output copl_pkg::copl_stat_t      stat,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic signed [15:0]        pixel_out,
    output logic                      saturated
);
    import copl_pkg::*;

    localparam int NB = MAX_IN_MAPS;

    logic [6:0]  in_w_reg, in_h_reg, out_w_reg, out_h_reg;
    logic [2:0]  kw_reg, kh_reg, maps_reg;
    logic [15:0] leak_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_w_reg  <= 7'd64;
            in_h_reg  <= 7'd64;
            out_w_reg <= 7'd64;
            out_h_reg <= 7'd64;
            kw_reg    <= 3'd3;
            kh_reg    <= 3'd3;
            maps_reg  <= 3'd1;
            leak_reg  <= 16'd655;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_IN_WIDTH:   in_w_reg  <= clamp_dim(cfg_data[6:0]);
                CFG_IN_HEIGHT:  in_h_reg  <= clamp_dim(cfg_data[6:0]);
                CFG_OUT_WIDTH:  out_w_reg <= clamp_dim(cfg_data[6:0]);
                CFG_OUT_HEIGHT: out_h_reg <= clamp_dim(cfg_data[6:0]);
                CFG_KERNEL_W:   kw_reg    <= clamp_kernel(cfg_data[2:0]);
                CFG_KERNEL_H:   kh_reg    <= clamp_kernel(cfg_data[2:0]);
                CFG_NUM_MAPS:   maps_reg  <= clamp_maps(cfg_data[2:0]);
                CFG_LEAK:       leak_reg  <= cfg_data;
                default:        leak_reg  <= leak_reg;
            endcase
        end
    end

    // centre = (2*pos*in + out) / (2*out)
    logic [DIV_NW-1:0] num_x, num_y, cx, cy;
    logic              busy_x, busy_y;

    assign num_x = DIV_NW'({pos_x, 1'b0}) * DIV_NW'(in_w_reg) + DIV_NW'(out_w_reg);
    assign num_y = DIV_NW'({pos_y, 1'b0}) * DIV_NW'(in_h_reg) + DIV_NW'(out_h_reg);

    copl_div u_div_x (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.load),
        .num   (num_x),
        .den   ({out_w_reg, 1'b0}),
        .busy  (busy_x),
        .quo   (cx)
    );

    copl_div u_div_y (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.load),
        .num   (num_y),
        .den   ({out_h_reg, 1'b0}),
        .busy  (busy_y),
        .quo   (cy)
    );

    logic [2:0] om_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            om_reg <= out_map;
        end
    end

    // window scan
    logic [2:0] dx_reg, dy_reg;
    logic [7:0] wbase_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.scan_init)
        begin
            dx_reg    <= '0;
            dy_reg    <= '0;
            wbase_reg <= '0;
        end
        else if (cmd.scan_step)
        begin
            wbase_reg <= wbase_reg + {5'd0, maps_reg};
            if (dy_reg == kh_reg - 1'b1)
            begin
                dy_reg <= '0;
                dx_reg <= dx_reg + 1'b1;
            end
            else
            begin
                dy_reg <= dy_reg + 1'b1;
            end
        end
    end

    logic signed [15:0] xo, yo;
    logic               inb;

    assign xo  = $signed({2'b00, cx}) + $signed({13'd0, dx_reg})
               - $signed({13'd0, kw_reg >> 1});
    assign yo  = $signed({2'b00, cy}) + $signed({13'd0, dy_reg})
               - $signed({13'd0, kh_reg >> 1});
    assign inb = !xo[15] && !yo[15] && (xo < $signed({9'd0, in_w_reg}))
              && (yo < $signed({9'd0, in_h_reg}));

    function automatic logic [WB_AW-1:0] om_wr_rows(input logic [2:0] m);
        return WB_AW'(m) * WB_AW'(KROWS);
    endfunction

    logic [PIX_AW-1:0] pix_raddr, pix_waddr;
    logic [WB_AW-1:0]  wt_waddr;
    logic [15:0]       prd [NB];
    logic [15:0]       wrd [NB];
    logic [1:0]        sel [NB];
    logic [1:0]        s1_sel_reg [NB];
    logic [NB-1:0]     en;
    logic [NB-1:0]     s1_en_reg;
    logic              s1_valid_reg, s2_valid_reg;
    logic signed [31:0] prod_reg [NB];

    assign pix_raddr = {yo[5:0], xo[5:0]};
    assign pix_waddr = {pos_y, pos_x};
    assign wt_waddr  = WB_AW'(om_wr_rows(out_map)) + WB_AW'(weight_index[7:2]);

    genvar b;
    generate
        for (b = 0; b < NB; b++)
        begin : g_bank
            logic [7:0]       idx;
            logic [WB_AW-1:0] raddr;

            assign sel[b] = 2'(b) - wbase_reg[1:0];
            assign idx    = wbase_reg + {6'd0, sel[b]};
            assign en[b]  = inb && ({1'b0, sel[b]} < maps_reg);
            assign raddr  = om_wr_rows(om_reg) + WB_AW'(idx[7:2]);

            copl_ram #(
                .WIDTH (16),
                .DEPTH (PIX_DEPTH)
            ) u_pix (
                .clk   (clk),
                .we    (cmd.wr_pixel && (in_map == 2'(b))),
                .waddr (pix_waddr),
                .wdata (data_value),
                .raddr (pix_raddr),
                .rdata (prd[b])
            );

            copl_ram #(
                .WIDTH (16),
                .DEPTH (WB_DEPTH)
            ) u_wt (
                .clk   (clk),
                .we    (cmd.wr_weight && (weight_index < 8'(KSLOTS))
                        && (weight_index[1:0] == 2'(b))),
                .waddr (wt_waddr),
                .wdata (data_value),
                .raddr (raddr),
                .rdata (wrd[b])
            );

            always_ff @(posedge clk)
            begin
                s1_sel_reg[b] <= sel[b];
                if (s1_en_reg[b])
                    prod_reg[b] <= $signed(wrd[b]) * $signed(prd[s1_sel_reg[b]]);
                else
                    prod_reg[b] <= '0;
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s1_en_reg    <= '0;
        end
        else
        begin
            s1_valid_reg <= cmd.scan_step;
            s2_valid_reg <= s1_valid_reg;
            s1_en_reg    <= cmd.scan_step ? en : '0;
        end
    end

    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] psum;

    always_comb
    begin
        psum = '0;
        for (int i = 0; i < NB; i++)
        begin
            psum = psum + ACC_W'(prod_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_init)
            acc_reg <= '0;
        else if (s2_valid_reg)
            acc_reg <= acc_reg + psum;
    end

    // activation and rounding
    logic signed [36:0] hi_reg;
    logic [35:0]        lo_reg;
    logic               pos_reg;
    logic signed [57:0] leaked;
    logic signed [ACC_W-1:0] t_pos;
    logic signed [57:0] t_neg;
    logic signed [RES_W-1:0] res;
    logic signed [15:0] res_reg;
    logic               sat_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            hi_reg  <= $signed(acc_reg[ACC_W-1:20]) * $signed({1'b0, leak_reg});
            lo_reg  <= acc_reg[19:0] * leak_reg;
            pos_reg <= acc_reg > 0;
        end
    end

    assign leaked = ($signed(58'(hi_reg)) <<< 20) + $signed({22'd0, lo_reg});
    assign t_pos  = acc_reg + ACC_W'(1 << 13);
    assign t_neg  = leaked + 58'(1 << 29);
    assign res    = pos_reg ? RES_W'(t_pos >>> 14) : RES_W'(t_neg >>> 30);

    always_ff @(posedge clk)
    begin
        if (cmd.round)
        begin
            if (res > 28'sd32767)
            begin
                res_reg <= 16'sh7fff;
                sat_reg <= 1'b1;
            end
            else if (res < -28'sd32768)
            begin
                res_reg <= 16'sh8000;
                sat_reg <= 1'b1;
            end
            else
            begin
                res_reg <= res[15:0];
                sat_reg <= 1'b0;
            end
        end
    end

    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            pixel_out <= res_reg;
            saturated <= sat_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign stat.div_busy  = busy_x || busy_y;
    assign stat.scan_last = (dx_reg == kw_reg - 1'b1) && (dy_reg == kh_reg - 1'b1);
    assign stat.pipe_busy = s1_valid_reg || s2_valid_reg;
    assign stat.out_free  = !out_valid_reg || out_ready;

endmodule
`default_nettype wire

@@ rtl/conv_output_pixel_leaky_relu_unit.sv @@
// weight and pixel writes leave the block ready for the next word
// a query runs the centre divider and scan start, steps through each kernel position,
// waits for the pipeline to drain, then does the leak multiply, rounding and the output
// register; no new word is taken until the result is loaded into the output register;
// input maps are read in parallel banks
// rst_n resets control and configuration registers; pixel and weight stores are not cleared
`default_nettype none
module conv_output_pixel_leaky_relu_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,  // out_map, in_map, pos_x, pos_y, weight_index, data_value
    input  wire logic [1:0]  s_axis_tuser,  // op
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,  // pixel_out
    output logic             m_axis_tuser,  // saturated
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import copl_pkg::*;

    copl_cmd_t  cmd;
    copl_stat_t stat;
    logic signed [15:0] pixel_out;

    assign cfg_ready = 1'b1;

    copl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .op       (s_axis_tuser),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    copl_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_map      (s_axis_tdata[2:0]),
        .in_map       (s_axis_tdata[4:3]),
        .pos_x        (s_axis_tdata[10:5]),
        .pos_y        (s_axis_tdata[16:11]),
        .weight_index (s_axis_tdata[24:17]),
        .data_value   (s_axis_tdata[40:25]),
        .cmd          (cmd),
        .stat         (stat),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .pixel_out    (pixel_out),
        .saturated    (m_axis_tuser)
    );

    assign m_axis_tdata = pixel_out;

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_QUERY)) |=> !s_axis_tready)
        else $error("block took a word right after a query");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
        (m_axis_tdata == 16'h7fff || m_axis_tdata == 16'h8000))
        else $error("saturation flag without a clipped value");

    a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared while idle");

endmodule
`default_nettype wire
